// ===== design/rccb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rccb_pkg
// Shared constants and helpers for the random cycle chain builder and walker.
// ----------------------------------------------------------------------------
package rccb_pkg;

    localparam int MAX_NODES = 4096;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int OFF_W     = 18;
    localparam int LOAD_W    = 32;
    localparam int TOTAL_W   = LOAD_W + 1;
    localparam int GEN_W     = 64;
    localparam int REM_W     = CNT_W;

    localparam logic [GEN_W-1:0] GOLDEN     = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [GEN_W-1:0] MIX1       = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [GEN_W-1:0] MIX2       = 64'h94D0_49BB_1331_11EB;
    localparam logic [GEN_W-1:0] SEED_RESET = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SEQ_MODE   = 2'd1;
    localparam logic [1:0] CFG_SIZE_SHIFT = 2'd2;
    localparam logic [1:0] CFG_SEED       = 2'd3;

    localparam logic REQ_BUILD = 1'b0;
    localparam logic REQ_WALK  = 1'b1;

    function automatic logic [2:0] clamp_shift(input logic [2:0] sh);
        logic [2:0] r;
        r = sh;
        if (sh < 3'd3)
        begin
            r = 3'd3;
        end
        else if (sh > 3'd6)
        begin
            r = 3'd6;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/random_cycle_chain_builder_walker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// random_cycle_chain_builder_walker
// Builds a single-cycle next-link table and walks it on request.
// ----------------------------------------------------------------------------
// Requests enter on s_*: s_tuser is the kind (0 build, 1 walk), s_tdata holds
// start_offset and load_count. One response leaves on m_* per request:
// m_tdata holds end_offset, m_tuser flags a build response.
// One request is worked on at a time; s_tready is high while idle.
// Build, sequential: one link written per node. Build, random: fill the
// shuffle table, then shuffle steps that each draw from the mixer and reduce
// with the remainder unit, then link the nodes in shuffled order.
// Walk: one link memory read per load; loads above 4096 walk a prefix of
// 4096 loads, measure the cycle length, take the remainder of the rest by
// that length and walk the remainder to finish.
// Reset clears control state and returns configuration to its defaults; the tables hold nothing
// valid until the first build. A stalled m_tready holds the response and
// blocks the next response from leaving; the next request is still taken.
// ----------------------------------------------------------------------------
module random_cycle_chain_builder_walker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // start_offset[17:0], load_count[49:18]
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // end_offset[17:0]
    output logic             m_tuser,   // build_done
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import rccb_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_BSEQ  = 4'd1;
    localparam logic [3:0] ST_BINIT = 4'd2;
    localparam logic [3:0] ST_MIXS  = 4'd3;
    localparam logic [3:0] ST_MIXW  = 4'd4;
    localparam logic [3:0] ST_DIVW  = 4'd5;
    localparam logic [3:0] ST_RDI   = 4'd6;
    localparam logic [3:0] ST_RDJ   = 4'd7;
    localparam logic [3:0] ST_SWP   = 4'd8;
    localparam logic [3:0] ST_SWP2  = 4'd9;
    localparam logic [3:0] ST_LISS  = 4'd10;
    localparam logic [3:0] ST_LCAP  = 4'd11;
    localparam logic [3:0] ST_LFIN  = 4'd12;
    localparam logic [3:0] ST_WISS  = 4'd13;
    localparam logic [3:0] ST_WCAP  = 4'd14;
    localparam logic [3:0] ST_WDIV  = 4'd15;

    localparam logic [1:0] PH_PREFIX  = 2'd0;
    localparam logic [1:0] PH_MEASURE = 2'd1;
    localparam logic [1:0] PH_REST    = 2'd2;

    localparam logic [TOTAL_W-1:0] PREFIX = TOTAL_W'(MAX_NODES);

    logic [IDX_W-1:0] link_mem [MAX_NODES];
    logic [IDX_W-1:0] shuf_mem [MAX_NODES];
    logic [IDX_W-1:0] link_rdata_reg;
    logic [IDX_W-1:0] shuf_rdata_reg;

    logic [CNT_W-1:0] node_count_reg;
    logic             seq_mode_reg;
    logic [2:0]       size_shift_reg;

    logic [3:0]         state_reg;
    logic               busy_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [IDX_W-1:0]   shi_reg;
    logic [IDX_W-1:0]   first_reg;
    logic [IDX_W-1:0]   prev_reg;
    logic [IDX_W-1:0]   cur_reg;
    logic [IDX_W-1:0]   mark_reg;
    logic [CNT_W-1:0]   clen_reg;
    logic [TOTAL_W-1:0] left_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [1:0]         phase_reg;
    logic [OFF_W-1:0]   res_off_reg;
    logic               res_build_reg;
    logic               res_ready_reg;
    logic               out_valid_reg;
    logic [OFF_W-1:0]   out_off_reg;
    logic               out_build_reg;

    logic               lw_en;
    logic [IDX_W-1:0]   lw_addr;
    logic [IDX_W-1:0]   lw_data;
    logic [IDX_W-1:0]   lr_addr;
    logic               sw_en;
    logic [IDX_W-1:0]   sw_addr;
    logic [IDX_W-1:0]   sw_data;
    logic [IDX_W-1:0]   sr_addr;

    logic [CNT_W-1:0]   n_eff;
    logic [2:0]         eff_sh;
    logic               accept;
    logic               out_load;
    logic [OFF_W-1:0]   in_start;
    logic [LOAD_W-1:0]  in_loads;
    logic [TOTAL_W-1:0] in_total;
    logic [OFF_W-1:0]   start_node;
    logic [OFF_W-1:0]   cur_off;
    logic [CNT_W-1:0]   clen_inc;
    logic               cyc_closed;

    logic               mix_start;
    logic               mix_done;
    logic [GEN_W-1:0]   mix_value;
    logic               div_start;
    logic [GEN_W-1:0]   div_dividend;
    logic [REM_W-1:0]   div_divisor;
    logic               div_done;
    logic [REM_W-1:0]   div_rem;

    assign n_eff      = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                            : node_count_reg;
    assign eff_sh     = clamp_shift(size_shift_reg);
    assign s_tready   = !busy_reg;
    assign accept     = s_tvalid && s_tready;
    assign in_start   = s_tdata[17:0];
    assign in_loads   = s_tdata[49:18];
    assign in_total   = ({1'b0, in_loads} + TOTAL_W'(7)) & ~TOTAL_W'(7);
    assign start_node = in_start >> eff_sh;
    assign cur_off    = {{(OFF_W-IDX_W){1'b0}}, cur_reg} << eff_sh;
    assign clen_inc   = clen_reg + 1'b1;
    assign cyc_closed = (phase_reg == PH_MEASURE) && (link_rdata_reg == mark_reg);
    assign out_load   = res_ready_reg && (!out_valid_reg || m_tready);

    assign mix_start    = (state_reg == ST_MIXS);
    assign div_start    = ((state_reg == ST_MIXW) && mix_done)
                       || ((state_reg == ST_WCAP) && cyc_closed);
    assign div_dividend = (state_reg == ST_WCAP)
                        ? {{(GEN_W-TOTAL_W){1'b0}}, total_reg - PREFIX} : mix_value;
    assign div_divisor  = (state_reg == ST_WCAP) ? clen_inc : {1'b0, i_reg};

    rccb_mix u_mix
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (cfg_wr_en && (cfg_index == CFG_SEED)),
        .seed_value (cfg_data),
        .start      (mix_start),
        .done       (mix_done),
        .value      (mix_value)
    );

    rccb_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        lw_en   = 1'b0;
        lw_addr = prev_reg;
        lw_data = link_rdata_reg;
        lr_addr = cur_reg;
        sw_en   = 1'b0;
        sw_addr = i_reg;
        sw_data = shuf_rdata_reg;
        sr_addr = i_reg;
        case (state_reg)
            ST_BSEQ:
            begin
                lw_en   = 1'b1;
                lw_addr = k_reg[IDX_W-1:0];
                lw_data = (k_reg + 1'b1 == n_eff) ? '0 : IDX_W'(k_reg + 1'b1);
            end
            ST_BINIT:
            begin
                sw_en   = 1'b1;
                sw_addr = k_reg[IDX_W-1:0];
                sw_data = k_reg[IDX_W-1:0];
            end
            ST_RDJ:
            begin
                sr_addr = j_reg;
            end
            ST_SWP:
            begin
                sw_en = 1'b1;
            end
            ST_SWP2:
            begin
                sw_en   = 1'b1;
                sw_addr = j_reg;
                sw_data = shi_reg;
            end
            ST_LISS:
            begin
                sr_addr = k_reg[IDX_W-1:0];
            end
            ST_LCAP:
            begin
                lw_en   = (k_reg != '0);
                lw_data = shuf_rdata_reg;
            end
            ST_LFIN:
            begin
                lw_en   = 1'b1;
                lw_data = first_reg;
            end
            default:
            begin
                lw_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            link_mem[lw_addr] <= lw_data;
        end
        link_rdata_reg <= link_mem[lr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sw_en)
        begin
            shuf_mem[sw_addr] <= sw_data;
        end
        shuf_rdata_reg <= shuf_mem[sr_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_W'(MAX_NODES);
            seq_mode_reg   <= 1'b0;
            size_shift_reg <= 3'd6;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_NODE_COUNT: node_count_reg <= cfg_data[CNT_W-1:0];
                CFG_SEQ_MODE:   seq_mode_reg   <= cfg_data[0];
                CFG_SIZE_SHIFT: size_shift_reg <= cfg_data[2:0];
                default:        seq_mode_reg   <= seq_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
            out_off_reg   <= res_off_reg;
            out_build_reg <= res_build_reg;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            res_ready_reg <= 1'b0;
            phase_reg     <= PH_PREFIX;
        end
        else
        begin
            if (out_load)
            begin
                res_ready_reg <= 1'b0;
                busy_reg      <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        busy_reg <= 1'b1;
                        k_reg    <= '0;
                        if (s_tuser == REQ_BUILD)
                        begin
                            res_off_reg   <= '0;
                            res_build_reg <= 1'b1;
                            if (n_eff == '0)
                            begin
                                res_ready_reg <= 1'b1;
                            end
                            else if (seq_mode_reg)
                            begin
                                state_reg <= ST_BSEQ;
                            end
                            else
                            begin
                                state_reg <= ST_BINIT;
                            end
                        end
                        else
                        begin
                            res_build_reg <= 1'b0;
                            total_reg     <= in_total;
                            cur_reg       <= start_node[IDX_W-1:0];
                            left_reg      <= (in_total > PREFIX) ? PREFIX : in_total;
                            phase_reg     <= PH_PREFIX;
                            if (in_total == '0)
                            begin
                                res_off_reg   <= in_start;
                                res_ready_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= ST_WISS;
                            end
                        end
                    end
                end
                ST_BSEQ:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg + 1'b1 == n_eff)
                    begin
                        res_ready_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_BINIT:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg + 1'b1 == n_eff)
                    begin
                        i_reg <= IDX_W'(n_eff - 1'b1);
                        if (n_eff == CNT_W'(1))
                        begin
                            k_reg     <= '0;
                            state_reg <= ST_LISS;
                        end
                        else
                        begin
                            state_reg <= ST_MIXS;
                        end
                    end
                end
                ST_MIXS:
                begin
                    state_reg <= ST_MIXW;
                end
                ST_MIXW:
                begin
                    if (mix_done)
                    begin
                        state_reg <= ST_DIVW;
                    end
                end
                ST_DIVW:
                begin
                    if (div_done)
                    begin
                        j_reg     <= div_rem[IDX_W-1:0];
                        state_reg <= ST_RDI;
                    end
                end
                ST_RDI:
                begin
                    state_reg <= ST_RDJ;
                end
                ST_RDJ:
                begin
                    shi_reg   <= shuf_rdata_reg;
                    state_reg <= ST_SWP;
                end
                ST_SWP:
                begin
                    state_reg <= ST_SWP2;
                end
                ST_SWP2:
                begin
                    if (i_reg == IDX_W'(1))
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_LISS;
                    end
                    else
                    begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= ST_MIXS;
                    end
                end
                ST_LISS:
                begin
                    state_reg <= ST_LCAP;
                end
                ST_LCAP:
                begin
                    prev_reg <= shuf_rdata_reg;
                    if (k_reg == '0)
                    begin
                        first_reg <= shuf_rdata_reg;
                    end
                    if (k_reg + 1'b1 == n_eff)
                    begin
                        state_reg <= ST_LFIN;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_LISS;
                    end
                end
                ST_LFIN:
                begin
                    res_ready_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                ST_WISS:
                begin
                    if ((phase_reg != PH_MEASURE) && (left_reg == '0))
                    begin
                        if ((phase_reg == PH_PREFIX) && (total_reg > PREFIX))
                        begin
                            mark_reg  <= cur_reg;
                            clen_reg  <= '0;
                            phase_reg <= PH_MEASURE;
                        end
                        else
                        begin
                            res_off_reg   <= cur_off;
                            res_ready_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_WCAP;
                    end
                end
                ST_WCAP:
                begin
                    cur_reg <= link_rdata_reg;
                    if (phase_reg == PH_MEASURE)
                    begin
                        clen_reg  <= clen_inc;
                        state_reg <= cyc_closed ? ST_WDIV : ST_WISS;
                    end
                    else
                    begin
                        left_reg  <= left_reg - 1'b1;
                        state_reg <= ST_WISS;
                    end
                end
                ST_WDIV:
                begin
                    if (div_done)
                    begin
                        left_reg  <= {{(TOTAL_W-REM_W){1'b0}}, div_rem};
                        phase_reg <= PH_REST;
                        state_reg <= ST_WISS;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24-OFF_W){1'b0}}, out_off_reg};
    assign m_tuser  = out_build_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("request taken without entering work");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid)
        else $error("response loaded but not presented");

    a_measure_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WDIV) |-> (clen_reg != '0))
        else $error("cycle length zero at remainder step");

endmodule
`default_nettype wire

// ===== design/rccb_mix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rccb_mix
// Generator state and output mixer, one 32x32 partial product per cycle while no seed is written.
// ----------------------------------------------------------------------------
module rccb_mix
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      seed_we,
    input  wire logic [rccb_pkg::GEN_W-1:0] seed_value,
    input  wire logic                      start,
    output logic                           done,
    output logic [rccb_pkg::GEN_W-1:0]     value
);
    import rccb_pkg::*;

    logic [GEN_W-1:0] gen_reg;
    logic [GEN_W-1:0] x_reg;
    logic [GEN_W-1:0] acc_reg;
    logic [GEN_W-1:0] value_reg;
    logic [1:0]       ph_reg;
    logic             stage_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [GEN_W-1:0] gen_next;
    logic [GEN_W-1:0] coef;
    logic [31:0]      m_a;
    logic [31:0]      m_b;
    logic [63:0]      prod;
    logic [GEN_W-1:0] acc_next;

    assign gen_next = gen_reg + GOLDEN;
    assign coef     = stage_reg ? MIX2 : MIX1;
    assign m_a      = (ph_reg == 2'd1) ? x_reg[63:32] : x_reg[31:0];
    assign m_b      = (ph_reg == 2'd2) ? coef[63:32] : coef[31:0];
    assign prod     = m_a * m_b;
    assign acc_next = acc_reg + {prod[31:0], 32'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg   <= SEED_RESET;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            ph_reg    <= 2'd0;
            stage_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (seed_we)
            begin
                gen_reg <= seed_value;
            end
            else if (start)
            begin
                gen_reg   <= gen_next;
                x_reg     <= gen_next ^ (gen_next >> 30);
                ph_reg    <= 2'd0;
                stage_reg <= 1'b0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        acc_reg <= prod;
                        ph_reg  <= 2'd1;
                    end
                    2'd1:
                    begin
                        acc_reg <= acc_next;
                        ph_reg  <= 2'd2;
                    end
                    default:
                    begin
                        ph_reg <= 2'd0;
                        if (!stage_reg)
                        begin
                            x_reg     <= acc_next ^ (acc_next >> 27);
                            stage_reg <= 1'b1;
                        end
                        else
                        begin
                            value_reg <= acc_next ^ (acc_next >> 31);
                            done_reg  <= 1'b1;
                            busy_reg  <= 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule
`default_nettype wire

// ===== design/rccb_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rccb_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rccb_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [rccb_pkg::GEN_W-1:0] dividend,
    input  wire logic [rccb_pkg::REM_W-1:0] divisor,
    output logic                            done,
    output logic [rccb_pkg::REM_W-1:0]      remainder
);
    import rccb_pkg::*;

    localparam int STEP_W = $clog2(GEN_W);

    logic [GEN_W-1:0]  dvd_reg;
    logic [REM_W-1:0]  dvs_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W:0]    trial;
    logic [REM_W-1:0]  rem_next;

    assign trial    = {rem_reg, dvd_reg[GEN_W-1]};
    assign rem_next = (trial >= {1'b0, dvs_reg}) ? REM_W'(trial - {1'b0, dvs_reg})
                                                 : trial[REM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(GEN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire
